// ----- design/pcms_pkg.sv -----
// Shared types and widths for the pixel channel mean / standard deviation block.
// No dependencies; every other design file refers to this package by scoped names.
`default_nettype none

package pcms_pkg;

    // Pixel counter capacity is 2^PIXEL_COUNT_BITS
    localparam int PIXEL_COUNT_BITS = 24;

    localparam int CHAN_W   = 8;
    localparam int NUM_CH   = 4;
    localparam int CH_IDX_W = 2;
    localparam int FRAC_W   = 16;
    localparam int FIX_W    = 24;
    localparam int PIX_W    = 25;

    localparam int CNT_W   = PIXEL_COUNT_BITS + 1;
    localparam int SUM_W   = PIXEL_COUNT_BITS + CHAN_W;
    localparam int SQS_W   = PIXEL_COUNT_BITS + 2 * CHAN_W;
    localparam int SPLIT_W = SQS_W / 2;
    localparam int SQHI_W  = SQS_W - SPLIT_W;
    localparam int LO_W    = CNT_W + SPLIT_W;
    localparam int HI_W    = CNT_W + SQHI_W;
    localparam int PROD_W  = CNT_W + SQS_W;
    localparam int SQR_W   = 2 * SUM_W;
    localparam int ROOT_W  = (PROD_W + 2 * FRAC_W + 1) / 2;
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int MDVD_W  = SUM_W + FRAC_W;
    localparam int DIVD_W  = (MDVD_W > ROOT_W) ? MDVD_W : ROOT_W;

    localparam int DIV_CNT_W  = $clog2(DIVD_W + 1);
    localparam int SQRT_CNT_W = $clog2(ROOT_W + 1);

    localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(1) << PIXEL_COUNT_BITS;

    // Configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam int CFG_W  = 3;
    localparam logic [CFG_W-1:0] CH_USE_RESET = 3'd4;
    localparam logic REG_CH_USE = 1'b0;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        logic              last_pixel;
    } pixel_t;

    typedef struct packed {
        logic [CH_IDX_W-1:0] channel_index;
        logic [FIX_W-1:0]    mean_fixed;
        logic [FIX_W-1:0]    stddev_fixed;
        logic [PIX_W-1:0]    pixels_counted;
        logic                overflowed;
        logic                last_result;
    } result_t;

    typedef struct packed {
        logic                accum;
        logic                clear;
        logic                mul0;
        logic                mul1;
        logic                add;
        logic                sqrt_start;
        logic                div_start;
        logic                div_sd;
        logic                save_mean;
        logic                load_out;
        logic                last;
        logic [CH_IDX_W-1:0] ch;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic sqrt_busy;
        logic out_free;
    } ctrl_status_t;

endpackage

`default_nettype wire

// ----- design/pcms_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Uses pcms_pkg for widths.
`default_nettype none

module pcms_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [pcms_pkg::DIVD_W-1:0]   dividend,
    input  wire logic [pcms_pkg::CNT_W-1:0]    divisor,
    output logic                               busy,
    output logic [pcms_pkg::DIVD_W-1:0]        quotient
);

    logic                              busy_reg;
    logic [pcms_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic [pcms_pkg::CNT_W-1:0]        rem_reg;
    logic [pcms_pkg::DIVD_W-1:0]       quo_reg;
    logic [pcms_pkg::CNT_W-1:0]        dvs_reg;

    logic [pcms_pkg::CNT_W:0] shifted;
    logic [pcms_pkg::CNT_W:0] trial;
    logic                     fits;

    assign shifted = {rem_reg, quo_reg[pcms_pkg::DIVD_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};
    assign fits    = !trial[pcms_pkg::CNT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= pcms_pkg::DIV_CNT_W'(pcms_pkg::DIVD_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == pcms_pkg::DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial[pcms_pkg::CNT_W-1:0] : shifted[pcms_pkg::CNT_W-1:0];
            quo_reg <= {quo_reg[pcms_pkg::DIVD_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- design/pcms_sqrt.sv -----
// Digit-by-digit integer square root, one root bit per cycle.
// Uses pcms_pkg for widths.
`default_nettype none

module pcms_sqrt (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [pcms_pkg::RAD_W-1:0]   radicand,
    output logic                              busy,
    output logic [pcms_pkg::ROOT_W-1:0]       root
);

    localparam int REM_W = pcms_pkg::ROOT_W + 1;

    logic                               busy_reg;
    logic [pcms_pkg::SQRT_CNT_W-1:0]    cnt_reg;
    logic [pcms_pkg::RAD_W-1:0]         rad_reg;
    logic [REM_W-1:0]                   rem_reg;
    logic [pcms_pkg::ROOT_W-1:0]        root_reg;

    logic [REM_W+1:0] shifted;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    logic             fits;

    // bring down the next two radicand bits, test (root*4 + 1)
    assign shifted = {rem_reg, rad_reg[pcms_pkg::RAD_W-1 -: 2]};
    assign trial   = (REM_W + 2)'({root_reg, 2'b01});
    assign fits    = shifted >= trial;
    assign diff    = shifted - trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= pcms_pkg::SQRT_CNT_W'(pcms_pkg::ROOT_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == pcms_pkg::SQRT_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[pcms_pkg::RAD_W-3:0], 2'b00};
            rem_reg  <= fits ? diff[REM_W-1:0] : shifted[REM_W-1:0];
            root_reg <= {root_reg[pcms_pkg::ROOT_W-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// ----- design/pcms_datapath.sv -----
// Accumulators, variance arithmetic, result register.
// Uses pcms_pkg; instantiates pcms_div and pcms_sqrt.
`default_nettype none

module pcms_datapath (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire pcms_pkg::ctrl_cmd_t      cmd,
    output pcms_pkg::ctrl_status_t        status,
    input  wire pcms_pkg::pixel_t         pixel,
    output logic                          result_valid,
    input  wire logic                     result_stall,
    output pcms_pkg::result_t             result
);

    logic [pcms_pkg::CNT_W-1:0]  count_reg;
    logic                        ovf_reg;
    logic [pcms_pkg::SUM_W-1:0]  sum_reg [pcms_pkg::NUM_CH];
    logic [pcms_pkg::SQS_W-1:0]  sqs_reg [pcms_pkg::NUM_CH];

    logic [pcms_pkg::LO_W-1:0]   lo_reg;
    logic [pcms_pkg::HI_W-1:0]   hi_reg;
    logic [pcms_pkg::SQR_W-1:0]  sq_reg;
    logic [pcms_pkg::PROD_W-1:0] a_reg;
    logic [pcms_pkg::FIX_W-1:0]  mean_reg;

    logic                        out_valid_reg;
    pcms_pkg::result_t           out_reg;

    logic [pcms_pkg::CHAN_W-1:0]   chan [pcms_pkg::NUM_CH];
    logic [2*pcms_pkg::CHAN_W-1:0] chan_sq [pcms_pkg::NUM_CH];
    logic [pcms_pkg::SUM_W-1:0]    sum_sel;
    logic [pcms_pkg::SQS_W-1:0]    sqs_sel;
    logic [pcms_pkg::LO_W-1:0]     lo_next;
    logic [pcms_pkg::HI_W-1:0]     hi_next;
    logic [pcms_pkg::SQR_W-1:0]    sq_next;
    logic [pcms_pkg::PROD_W:0]     var_diff;
    logic [pcms_pkg::PROD_W-1:0]   var_clamped;
    logic [pcms_pkg::RAD_W-1:0]    radicand;
    logic [pcms_pkg::DIVD_W-1:0]   dividend;
    logic                          div_busy;
    logic [pcms_pkg::DIVD_W-1:0]   quotient;
    logic                          sqrt_busy;
    logic [pcms_pkg::ROOT_W-1:0]   root;
    logic                          out_free;

    assign chan[0] = pixel.red;
    assign chan[1] = pixel.green;
    assign chan[2] = pixel.blue;
    assign chan[3] = pixel.alpha;

    always_comb
    begin
        for (int i = 0; i < pcms_pkg::NUM_CH; i++)
        begin
            chan_sq[i] = chan[i] * chan[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            for (int i = 0; i < pcms_pkg::NUM_CH; i++)
            begin
                sum_reg[i] <= '0;
                sqs_reg[i] <= '0;
            end
        end
        else if (cmd.clear)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            for (int i = 0; i < pcms_pkg::NUM_CH; i++)
            begin
                sum_reg[i] <= '0;
                sqs_reg[i] <= '0;
            end
        end
        else if (cmd.accum)
        begin
            // full counter: drop the pixel, remember it
            if (count_reg == pcms_pkg::CAPACITY)
            begin
                ovf_reg <= 1'b1;
            end
            else
            begin
                count_reg <= count_reg + 1'b1;
                for (int i = 0; i < pcms_pkg::NUM_CH; i++)
                begin
                    sum_reg[i] <= sum_reg[i] + pcms_pkg::SUM_W'(chan[i]);
                    sqs_reg[i] <= sqs_reg[i] + pcms_pkg::SQS_W'(chan_sq[i]);
                end
            end
        end
    end

    assign sum_sel = sum_reg[cmd.ch];
    assign sqs_sel = sqs_reg[cmd.ch];

    // n * sumsq split into two partial products
    assign lo_next = pcms_pkg::LO_W'(count_reg)
                   * pcms_pkg::LO_W'(sqs_sel[pcms_pkg::SPLIT_W-1:0]);
    assign hi_next = pcms_pkg::HI_W'(count_reg)
                   * pcms_pkg::HI_W'(sqs_sel[pcms_pkg::SQS_W-1:pcms_pkg::SPLIT_W]);
    assign sq_next = pcms_pkg::SQR_W'(sum_sel) * pcms_pkg::SQR_W'(sum_sel);

    always_ff @(posedge clk)
    begin
        if (cmd.mul0)
        begin
            lo_reg <= lo_next;
            sq_reg <= sq_next;
        end
        if (cmd.mul1)
        begin
            hi_reg <= hi_next;
        end
        if (cmd.add)
        begin
            a_reg <= pcms_pkg::PROD_W'(lo_reg)
                   + (pcms_pkg::PROD_W'(hi_reg) << pcms_pkg::SPLIT_W);
        end
        if (cmd.save_mean)
        begin
            mean_reg <= quotient[pcms_pkg::FIX_W-1:0];
        end
    end

    // n*sumsq - sum^2, floored at zero, then scaled by 2^32
    assign var_diff    = {1'b0, a_reg} - (pcms_pkg::PROD_W + 1)'(sq_reg);
    assign var_clamped = var_diff[pcms_pkg::PROD_W] ? '0 : var_diff[pcms_pkg::PROD_W-1:0];
    assign radicand    = pcms_pkg::RAD_W'({var_clamped, {(2*pcms_pkg::FRAC_W){1'b0}}});

    assign dividend = cmd.div_sd ? pcms_pkg::DIVD_W'(root)
                                 : pcms_pkg::DIVD_W'({sum_sel, {pcms_pkg::FRAC_W{1'b0}}});

    pcms_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (count_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    pcms_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (radicand),
        .busy     (sqrt_busy),
        .root     (root)
    );

    assign out_free = !out_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg.channel_index  <= cmd.ch;
            out_reg.mean_fixed     <= mean_reg;
            out_reg.stddev_fixed   <= quotient[pcms_pkg::FIX_W-1:0];
            out_reg.pixels_counted <= pcms_pkg::PIX_W'(count_reg);
            out_reg.overflowed     <= ovf_reg;
            out_reg.last_result    <= cmd.last;
        end
    end

    assign status.div_busy  = div_busy;
    assign status.sqrt_busy = sqrt_busy;
    assign status.out_free  = out_free;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

// ----- design/pcms_ctrl.sv -----
// Sequencer: pixel intake, then per-channel mean / deviation steps at image end.
// Uses pcms_pkg command and status structs.
`default_nettype none

module pcms_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        pixel_valid,
    input  wire logic                        last_pixel,
    input  wire logic [pcms_pkg::CFG_W-1:0]  ch_use,
    input  wire pcms_pkg::ctrl_status_t      status,
    output pcms_pkg::ctrl_cmd_t              cmd,
    output logic                             pixel_stall
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL0 = 3'd1;
    localparam logic [2:0] S_MUL1 = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_SUB  = 3'd4;
    localparam logic [2:0] S_SQRT = 3'd5;
    localparam logic [2:0] S_DIVS = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]                       state_reg;
    logic [2:0]                       state_next;
    logic [pcms_pkg::CH_IDX_W-1:0]    ch_reg;
    logic [pcms_pkg::CH_IDX_W-1:0]    ch_next;
    logic [pcms_pkg::CH_IDX_W-1:0]    last_ch;

    // zero counts as one channel, anything above four as four
    always_comb
    begin
        if (ch_use == '0)
        begin
            last_ch = '0;
        end
        else if (ch_use > pcms_pkg::CFG_W'(pcms_pkg::NUM_CH))
        begin
            last_ch = pcms_pkg::CH_IDX_W'(pcms_pkg::NUM_CH - 1);
        end
        else
        begin
            last_ch = pcms_pkg::CH_IDX_W'(ch_use - 1'b1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        cmd        = '0;
        cmd.ch     = ch_reg;
        cmd.last   = (ch_reg == last_ch);
        case (state_reg)
            S_IDLE:
            begin
                cmd.accum = pixel_valid;
                if (pixel_valid && last_pixel)
                begin
                    ch_next    = '0;
                    state_next = S_MUL0;
                end
            end
            S_MUL0:
            begin
                cmd.mul0      = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = S_SUB;
            end
            S_SUB:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = S_SQRT;
            end
            S_SQRT:
            begin
                // mean quotient is saved as the divider is restarted on the root
                if (!status.sqrt_busy && !status.div_busy)
                begin
                    cmd.save_mean = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sd    = 1'b1;
                    state_next    = S_DIVS;
                end
            end
            S_DIVS:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (ch_reg == last_ch)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = S_MUL0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ch_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
        end
    end

    assign pixel_stall = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// ----- design/pixel_channel_mean_stddev.sv -----
// Top level: configuration register, sequencer and datapath.
// Uses pcms_pkg; instantiates pcms_ctrl and pcms_datapath.
`default_nettype none

// Per-channel mean and population standard deviation of an RGBA pixel
// stream. While pixel_stall is low, pixels are taken one per cycle and
// summed into per-channel sum and sum-of-squares accumulators; pixels past
// 2^24 are dropped and flagged. The word marked last_pixel is accumulated
// and then pixel_stall rises while one result word per channel in use
// (register 0, byte address 0) is built: after the multiply and subtract
// steps, the 49-step bit-serial square root is followed by the 49-step
// restoring divider. Pixels are taken again once the last result word of
// the image is loaded into the output register.
module pixel_channel_mean_stddev (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pcms_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [pcms_pkg::DATA_W-1:0]   pwdata,
    output logic [pcms_pkg::DATA_W-1:0]        prdata,
    output logic                               pready,
    input  wire logic                          pixel_valid,
    output logic                               pixel_stall,
    input  wire pcms_pkg::pixel_t              pixel,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output pcms_pkg::result_t                  result
);

    logic [pcms_pkg::CFG_W-1:0] ch_use_reg;
    logic                       reg_sel;
    pcms_pkg::ctrl_cmd_t        cmd;
    pcms_pkg::ctrl_status_t     status;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[pcms_pkg::ADDR_W-1] == pcms_pkg::REG_CH_USE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_use_reg <= pcms_pkg::CH_USE_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            ch_use_reg <= pwdata[pcms_pkg::CFG_W-1:0];
        end
    end

    assign prdata = reg_sel ? pcms_pkg::DATA_W'(ch_use_reg) : '0;

    pcms_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .last_pixel  (pixel.last_pixel),
        .ch_use      (ch_use_reg),
        .status      (status),
        .cmd         (cmd),
        .pixel_stall (pixel_stall)
    );

    pcms_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

// ----- design/pcms_checker.sv -----
// Port-level checks for pixel_channel_mean_stddev, bound to the top level.
// Uses pcms_pkg result type.
`default_nettype none

module pcms_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               pixel_stall,
    input  wire logic               result_valid,
    input  wire logic               result_stall,
    input  wire pcms_pkg::result_t  result
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result word changed");

    // every image counts at least one pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.pixels_counted != '0)
        else $error("result with empty pixel count");

    // an alpha result, when present, is always the last of the image
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_result |-> result.channel_index != 2'd3)
        else $error("alpha result not marked last");

    // intake stays closed until the last word of the image is out
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_result |-> pixel_stall)
        else $error("pixels taken mid-report");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.mean_fixed <= 24'hFF0000
                         && result.stddev_fixed <= 24'h800000)
        else $error("mean or deviation out of range");

endmodule

bind pixel_channel_mean_stddev pcms_checker u_pcms_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_stall  (pixel_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire
